// ===== hdl/small_matrix_add_sub_multiply_core_macros.svh =====
// Assertion macros shared by the matrix core RTL.
`ifndef SMALL_MATRIX_ADD_SUB_MULTIPLY_CORE_MACROS_SVH
`define SMALL_MATRIX_ADD_SUB_MULTIPLY_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SMAMS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SMAMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/smams_pkg.sv =====
// Package with the types and fixed widths of the matrix core.
`default_nettype none

package smams_pkg;

   localparam int VALUE_W    = 16;
   localparam int RESULT_W   = 33;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL
   } op_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ISSUE,
      ST_WAIT,
      ST_SEND
   } state_type;

   // One command to the shared arithmetic unit, issued with the RAM reads.
   typedef struct packed {
      logic   vld;
      op_type op;
      logic   first;
      logic   last;
   } mac_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/smams_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module smams_ram #(
   parameter  int WIDTH  = 16,
   parameter  int DEPTH  = 9,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/smams_mac.sv =====
// Shared add, subtract and multiply-accumulate unit of the matrix core.
`default_nettype none

module smams_mac
   import smams_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mac_ctl_type                ctl,
   input  wire logic signed [VALUE_W-1:0]  a_value,
   input  wire logic signed [VALUE_W-1:0]  b_value,
   output logic signed      [RESULT_W-1:0] result,
   output logic                            done
);

   mac_ctl_type                    ctl_ff;
   mac_ctl_type                    term_ctl_ff;
   logic signed [RESULT_W-1:0]     term_ff;
   logic signed [RESULT_W-1:0]     term_in;
   logic signed [RESULT_W-1:0]     acc_ff;
   logic signed [RESULT_W-1:0]     acc_in;
   logic                           done_ff;
   logic signed [2*VALUE_W-1:0]    prod;

   // The command is registered once so that it lines up with the registered RAM read data.
   always_comb begin
      prod = a_value * b_value;
      unique case (ctl_ff.op)
         OP_ADD: begin
            term_in = RESULT_W'(a_value) + RESULT_W'(b_value);
         end
         OP_SUB: begin
            term_in = RESULT_W'(a_value) - RESULT_W'(b_value);
         end
         default: begin
            term_in = RESULT_W'(prod);
         end
      endcase
   end

   // Product sums wrap to the result width, as two's complement arithmetic does.
   always_comb begin
      if (term_ctl_ff.first) begin
         acc_in = term_ff;
      end else begin
         acc_in = acc_ff + term_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.vld      <= 1'b0;
         term_ctl_ff.vld <= 1'b0;
         done_ff         <= 1'b0;
      end else begin
         ctl_ff.vld      <= ctl.vld;
         term_ctl_ff.vld <= ctl_ff.vld;
         done_ff         <= term_ctl_ff.vld & term_ctl_ff.last;
      end
      ctl_ff.op          <= ctl.op;
      ctl_ff.first       <= ctl.first;
      ctl_ff.last        <= ctl.last;
      term_ctl_ff.op     <= ctl_ff.op;
      term_ctl_ff.first  <= ctl_ff.first;
      term_ctl_ff.last   <= ctl_ff.last;
      term_ff            <= term_in;
      if (term_ctl_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   assign result = acc_ff;
   assign done   = done_ff;

endmodule

`default_nettype wire

// ===== hdl/small_matrix_add_sub_multiply_core.sv =====
// Top level of the small matrix add, subtract and multiply core.
`default_nettype none
`include "small_matrix_add_sub_multiply_core_macros.svh"

// The core loads two DIM x DIM signed 16-bit matrices A and B, one element of
// each per request in row-major order, and after the last pair it returns the
// DIM*DIM elements of the result matrix C in row-major order, with rsp_tlast
// set on the final one. The csr register selects element-wise A+B (0),
// element-wise A-B (1) or the matrix product (2; code 3 also gives the
// product); the mode is sampled when the last pair of a matrix arrives. Load
// requests are accepted back to back. Once the matrices are complete, req_tready
// stays low until the last result has been taken. Every result goes through
// one shared arithmetic unit behind two RAMs with registered read ports. A
// product result issues one product term per cycle through the single
// multiplier; each term passes the RAM read, the term register and the
// accumulator, and the result goes to the output register, where it is held
// while rsp_tready is low. Results of a product with DIM above 3 wrap to 33
// bits. There is no clearing pass after reset; the core accepts requests at
// once.
module small_matrix_add_sub_multiply_core
   import smams_pkg::*;
#(
   parameter int DIM = 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [15:0] first_value, [31:16] second_value
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Result channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [32:0] result_value, [39:33] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic                       rsp_tlast,
   // Mode register write port.
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_wdata
);

   localparam int CELLS = DIM * DIM;
   localparam int CNT_W = $clog2(CELLS);
   localparam int DIM_W = $clog2(DIM);

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;

   state_type                  state_ff;
   state_type                  state_in;
   logic [1:0]                 mode_ff;
   logic [1:0]                 mode_in;
   op_type                     run_op_ff;
   op_type                     run_op_in;
   // Load count while loading, result element index while returning results.
   logic [CNT_W-1:0]           cnt_ff;
   logic [CNT_W-1:0]           cnt_in;
   // Row start of A (row*DIM), current column, term index and its row start in B.
   logic [CNT_W-1:0]           row_base_ff;
   logic [CNT_W-1:0]           row_base_in;
   logic [DIM_W-1:0]           col_ff;
   logic [DIM_W-1:0]           col_in;
   logic [DIM_W-1:0]           k_ff;
   logic [DIM_W-1:0]           k_in;
   logic [CNT_W-1:0]           kb_ff;
   logic [CNT_W-1:0]           kb_in;
   logic [RESULT_W-1:0]        rsp_data_ff;
   logic [RESULT_W-1:0]        rsp_data_in;
   logic                       rsp_last_ff;
   logic                       rsp_last_in;

   logic                       ram_we;
   logic [CNT_W-1:0]           a_rd_addr;
   logic [CNT_W-1:0]           b_rd_addr;
   logic signed [VALUE_W-1:0]  a_rd_data;
   logic signed [VALUE_W-1:0]  b_rd_data;
   mac_ctl_type                mac_ctl;
   logic signed [RESULT_W-1:0] mac_result;
   logic                       mac_done;

   // Storage for the two operand matrices, addressed in row-major order.
   smams_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CELLS)
   ) u_a_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff),
      .wr_data (req_tdata[VALUE_W-1:0]),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   smams_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CELLS)
   ) u_b_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff),
      .wr_data (req_tdata[2*VALUE_W-1:VALUE_W]),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // The one arithmetic unit that every result element passes through.
   smams_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .a_value (a_rd_data),
      .b_value (b_rd_data),
      .result  (mac_result),
      .done    (mac_done)
   );

   // The mode register takes any write; it only matters when a matrix completes.
   always_comb begin
      mode_in = mode_ff;
      if (csr_we) begin
         mode_in = csr_wdata;
      end
   end

   // Sequencer: load the matrices, then for each result element issue its
   // reads and commands, wait for the accumulator and hand the result out.
   always_comb begin
      state_in      = state_ff;
      run_op_in     = run_op_ff;
      cnt_in        = cnt_ff;
      row_base_in   = row_base_ff;
      col_in        = col_ff;
      k_in          = k_ff;
      kb_in         = kb_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      ram_we        = 1'b0;
      a_rd_addr     = cnt_ff;
      b_rd_addr     = cnt_ff;
      mac_ctl.vld   = 1'b0;
      mac_ctl.op    = run_op_ff;
      mac_ctl.first = 1'b1;
      mac_ctl.last  = 1'b1;

      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ram_we = 1'b1;
               if (cnt_ff == CNT_W'(CELLS - 1)) begin
                  cnt_in      = '0;
                  row_base_in = '0;
                  col_in      = '0;
                  k_in        = '0;
                  kb_in       = '0;
                  state_in    = ST_ISSUE;
                  unique case (mode_ff)
                     MODE_ADD: run_op_in = OP_ADD;
                     MODE_SUB: run_op_in = OP_SUB;
                     default:  run_op_in = OP_MUL;
                  endcase
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_ISSUE: begin
            mac_ctl.vld = 1'b1;
            if (run_op_ff == OP_MUL) begin
               // One term A[row][k] * B[k][col] per cycle.
               a_rd_addr     = row_base_ff + CNT_W'(k_ff);
               b_rd_addr     = kb_ff + CNT_W'(col_ff);
               mac_ctl.first = (k_ff == '0);
               mac_ctl.last  = (k_ff == DIM_W'(DIM - 1));
               if (k_ff == DIM_W'(DIM - 1)) begin
                  k_in     = '0;
                  kb_in    = '0;
                  state_in = ST_WAIT;
               end else begin
                  k_in  = k_ff + DIM_W'(1);
                  kb_in = kb_ff + CNT_W'(DIM);
               end
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               rsp_data_in = mac_result;
               rsp_last_in = (cnt_ff == CNT_W'(CELLS - 1));
               state_in    = ST_SEND;
            end
         end
         ST_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (rsp_last_ff) begin
                  cnt_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  cnt_in   = cnt_ff + CNT_W'(1);
                  state_in = ST_ISSUE;
                  if (col_ff == DIM_W'(DIM - 1)) begin
                     col_in      = '0;
                     row_base_in = row_base_ff + CNT_W'(DIM);
                  end else begin
                     col_in = col_ff + DIM_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         mode_ff   <= MODE_ADD;
         run_op_ff <= OP_ADD;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         run_op_ff <= run_op_in;
         cnt_ff    <= cnt_in;
      end
      row_base_ff <= row_base_in;
      col_ff      <= col_in;
      k_ff        <= k_in;
      kb_ff       <= kb_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tdata = RSP_DATA_W'(rsp_data_ff);
   assign rsp_tlast = rsp_last_ff;

   // Loading and result delivery never overlap.
   `SMAMS_ASSERT_SAME(a_no_overlap, clock, reset,
      req_tready, !rsp_tvalid, "ready while result shown")
   // Completing a matrix pair stops further loads until the results are out.
   `SMAMS_ASSERT_NEXT(a_stop_after_fill, clock, reset,
      req_tvalid && req_tready && cnt_ff == CNT_W'(CELLS - 1), !req_tready,
      "load after full matrix")
   // After the final result is taken the core is ready for the next matrices.
   `SMAMS_ASSERT_NEXT(a_ready_after_last, clock, reset,
      rsp_tvalid && rsp_tready && rsp_tlast, req_tready && !rsp_tvalid,
      "not ready after last result")
   // The arithmetic unit finishes only while the sequencer waits for it.
   `SMAMS_ASSERT_SAME(a_done_in_wait, clock, reset,
      mac_done, state_ff == ST_WAIT, "result done outside wait")

endmodule

`default_nettype wire
